// ----- sv/utx_pkg.sv -----
// shared types and constants for the 8250-style transmit register block
// used by utx_front, utx_queue, utx_back and the top level
package utx_pkg;

  localparam int unsigned OVERSAMPLE_DEF = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned TIMER_W   = 20;
  localparam int unsigned DIV_W     = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFFSET_W  = 3;
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned FRAME_W   = 10;
  localparam int unsigned BITCNT_W  = 4;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // bus opcodes
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd2;

  // register offsets
  localparam logic [OFFSET_W-1:0] REG_DATA = 3'd0;
  localparam logic [OFFSET_W-1:0] REG_IER  = 3'd1;
  localparam logic [OFFSET_W-1:0] REG_IIR  = 3'd2;
  localparam logic [OFFSET_W-1:0] REG_LCR  = 3'd3;
  localparam logic [OFFSET_W-1:0] REG_LSR  = 3'd5;

  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam logic [BYTE_W-1:0] IIR_NONE_PENDING = 8'h01;
  localparam logic [BITCNT_W-1:0] FRAME_BITS = 4'd10;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_READ,
    CMD_WRITE,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [OFFSET_W-1:0]   offset;
    logic [BYTE_W-1:0]     data;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              serial_out;
    logic              holding_empty;
  } result_t;

endpackage

// ----- sv/uart_8250_transmit_registers_top.sv -----
// 8250-style uart register block with transmitter (8N1, lsb first). Each input
// item is a register read, a register write, one baud clock tick or a no-op
// (opcode 3), and each gives exactly one result item: read data, the line level
// and holding-empty status after the step. One item is taken per clock while
// the command queue is not full; a result passes the two-entry command queue,
// then the result register, and these let the input keep flowing for two items
// while the output is stalled. Each serial bit lasts max(divisor,1)*OVERSAMPLE
// ticks. Depends on utx_pkg, utx_front, utx_queue and utx_back.
module uart_8250_transmit_registers_top #(
  parameter int unsigned OVERSAMPLE  = utx_pkg::OVERSAMPLE_DEF,
  parameter int unsigned QUEUE_DEPTH = utx_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode[1:0], reg_offset[4:2], write_data[12:5], zero fill above
  input  logic [utx_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_data[7:0], serial_out[8], holding_empty[9], zero fill above
  output logic [utx_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import utx_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, pop, q_empty, q_full;

  utx_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .queue_full_i  (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  utx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  utx_back #(
    .OVERSAMPLE (OVERSAMPLE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (q_empty),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- sv/utx_front.sv -----
// front end: takes bus/tick items off the input stream and classifies them
// into commands for the queue; depends on utx_pkg
module utx_front (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode[1:0], reg_offset[4:2], write_data[12:5], zero fill above
  input  logic [utx_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              queue_full_i,
  output logic                              push_o,
  output utx_pkg::cmd_t                     cmd_o
);
  import utx_pkg::*;

  logic [OPCODE_W-1:0] opcode;

  assign opcode        = s_axis_tdata[OPCODE_W-1:0];
  assign s_axis_tready = !queue_full_i;
  assign push_o        = s_axis_tvalid && !queue_full_i;

  always_comb begin
    cmd_o.offset = s_axis_tdata[OPCODE_W +: OFFSET_W];
    cmd_o.data   = s_axis_tdata[OPCODE_W+OFFSET_W +: BYTE_W];
    unique case (opcode)
      OP_READ:  cmd_o.kind = CMD_READ;
      OP_WRITE: cmd_o.kind = CMD_WRITE;
      OP_TICK:  cmd_o.kind = CMD_TICK;
      default:  cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

// ----- sv/utx_queue.sv -----
// short command queue between front end and back end
// depends on utx_pkg
module utx_queue #(
  parameter int unsigned DEPTH = utx_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utx_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output utx_pkg::cmd_t pop_cmd_o,
  output logic          empty_o,
  output logic          full_o
);
  import utx_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o   = (cnt_q == '0);
  assign full_o    = (cnt_q == FULL_CNT);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- sv/utx_back.sv -----
// back end: register file, transmitter shifter and bit timer, result register
// depends on utx_pkg
module utx_back #(
  parameter int unsigned OVERSAMPLE = utx_pkg::OVERSAMPLE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              queue_empty_i,
  input  utx_pkg::cmd_t                     cmd_i,
  output logic                              pop_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_data[7:0], serial_out[8], holding_empty[9], zero fill above
  output logic [utx_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import utx_pkg::*;

  localparam logic [TIMER_W-1:0] OVS = TIMER_W'(OVERSAMPLE);
  localparam int unsigned RES_W = $bits(result_t);

  logic [DIV_W-1:0]    div_q, div_d;
  logic [BYTE_W-1:0]   lcr_q, lcr_d;
  logic [3:0]          ier_q, ier_d;
  logic [BYTE_W-1:0]   hold_q, hold_d;
  logic                hold_full_q, hold_full_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [BITCNT_W-1:0] bits_q, bits_d;
  logic [TIMER_W-1:0]  timer_q, timer_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q, out_d;

  logic [DIV_W-1:0]    div_eff;
  logic [TIMER_W-1:0]  period;
  logic [TIMER_W-1:0]  timer_dec;
  logic                dlab;
  logic [BYTE_W-1:0]   rd_val;
  logic [BYTE_W-1:0]   lsr_val;
  logic [BITCNT_W-1:0] bits_tmp;
  logic [FRAME_W-1:0]  frame_tmp;

  assign pop_o   = !queue_empty_i && (!out_valid_q || m_axis_tready);
  assign dlab    = lcr_q[LCR_DLAB_BIT];
  assign div_eff = (div_q == '0) ? DIV_W'(1) : div_q;
  assign period  = TIMER_W'(div_eff) * OVS;

  assign lsr_val = {1'b0, !hold_full_q && (bits_q == '0), !hold_full_q, 5'b0};

  always_comb begin
    unique case (cmd_i.offset)
      REG_DATA: rd_val = dlab ? div_q[BYTE_W-1:0] : '0;
      REG_IER:  rd_val = dlab ? div_q[DIV_W-1:BYTE_W] : {4'b0, ier_q};
      REG_IIR:  rd_val = IIR_NONE_PENDING;
      REG_LCR:  rd_val = lcr_q;
      REG_LSR:  rd_val = lsr_val;
      default:  rd_val = '0;
    endcase
  end

  always_comb begin
    div_d       = div_q;
    lcr_d       = lcr_q;
    ier_d       = ier_q;
    hold_d      = hold_q;
    hold_full_d = hold_full_q;
    frame_d     = frame_q;
    bits_d      = bits_q;
    timer_d     = timer_q;
    timer_dec   = (timer_q != '0) ? timer_q - TIMER_W'(1) : '0;
    bits_tmp    = bits_q;
    frame_tmp   = frame_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    if (pop_o) begin
      unique case (cmd_i.kind)
        CMD_WRITE: begin
          unique case (cmd_i.offset)
            REG_DATA: begin
              if (dlab) begin
                div_d[BYTE_W-1:0] = cmd_i.data;
              end else begin
                hold_d      = cmd_i.data;
                hold_full_d = 1'b1;
              end
            end
            REG_IER: begin
              if (dlab) begin
                div_d[DIV_W-1:BYTE_W] = cmd_i.data;
              end else begin
                ier_d = cmd_i.data[3:0];
              end
            end
            REG_LCR: lcr_d = cmd_i.data;
            default: ;
          endcase
        end
        CMD_TICK: begin
          if (bits_q != '0) begin
            timer_d = timer_dec;
            if (timer_dec == '0) begin
              frame_tmp = {1'b1, frame_q[FRAME_W-1:1]};
              bits_tmp  = bits_q - BITCNT_W'(1);
              if (bits_tmp != '0) begin
                timer_d = period;
              end
            end
          end
          frame_d = frame_tmp;
          bits_d  = bits_tmp;
          // a held byte enters the shifter on the tick the stop bit ends, or on any tick while the shifter is idle
          if (bits_tmp == '0 && hold_full_q) begin
            frame_d     = {1'b1, hold_q, 1'b0};
            bits_d      = FRAME_BITS;
            timer_d     = period;
            hold_full_d = 1'b0;
          end
        end
        default: ;
      endcase

      out_valid_d         = 1'b1;
      out_d.read_data     = (cmd_i.kind == CMD_READ) ? rd_val : '0;
      out_d.serial_out    = (bits_d != '0) ? frame_d[0] : 1'b1;
      out_d.holding_empty = !hold_full_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q       <= '0;
      lcr_q       <= '0;
      ier_q       <= '0;
      hold_q      <= '0;
      hold_full_q <= 1'b0;
      frame_q     <= '1;
      bits_q      <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      div_q       <= div_d;
      lcr_q       <= lcr_d;
      ier_q       <= ier_d;
      hold_q      <= hold_d;
      hold_full_q <= hold_full_d;
      frame_q     <= frame_d;
      bits_q      <= bits_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}},
                          out_q.holding_empty, out_q.serial_out, out_q.read_data};

endmodule

// ----- sv/utx_checker.sv -----
// port-level checks for the transmit register block, bound to the top level
// depends on utx_pkg
module utx_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [utx_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import utx_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // input backpressure only comes from a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // once an accepted item has passed the queue and the result register, a result is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("no result after accepted item");

  // fill bits above the result fields stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:10] == '0))
    else $error("nonzero fill bits in result");

endmodule

bind uart_8250_transmit_registers_top utx_checker u_utx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/testbench.sv -----
// self-checking bench for uart_8250_transmit_registers_top: bus reads, writes, ticks and no-op items
// go in on the slave stream, each result is checked against an in-bench transmitter model
// depends on utx_pkg and the top level of the block
module testbench;
  import utx_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
  localparam logic [OFFSET_W-1:0] REG_SCR = 3'd7;
  localparam int unsigned LSR_THRE_BIT = 5;
  localparam int unsigned LSR_TEMT_BIT = 6;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned CALM_TAIL = 200;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [OFFSET_W-1:0] off;
    logic [BYTE_W-1:0]   data;
  } bus_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  uart_8250_transmit_registers_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  bus_item_t bus_items[$];
  result_t   due_results[$];
  int        cycle_cnt = 0;
  int        errors = 0;
  int        items_taken = 0;
  int        reads_taken = 0;
  int        frames_started = 0;
  logic      in_taken = 1'b0;
  int        src_gap = 0;
  int        snk_gap = 0;
  int        idle_rate = 0;

  // transmitter model state
  logic [DIV_W-1:0]    m_divisor = '0;
  logic [BYTE_W-1:0]   m_lcr = '0;
  logic [3:0]          m_ier = '0;
  logic [BYTE_W-1:0]   m_thr = '0;
  logic                m_thr_full = 1'b0;
  logic [FRAME_W-1:0]  m_frame = '1;
  logic [BITCNT_W-1:0] m_bits = '0;
  logic [TIMER_W-1:0]  m_timer = '0;

  function automatic logic [TIMER_W-1:0] bit_ticks();
    logic [35:0] prod;
    prod = ((m_divisor == '0) ? 36'd1 : 36'(m_divisor)) * 36'(OVERSAMPLE_DEF);
    return prod[TIMER_W-1:0];
  endfunction

  task automatic step_uart(input bus_item_t it, output result_t res);
    logic dlab;
    logic [BYTE_W-1:0] rd;
    dlab = m_lcr[LCR_DLAB_BIT];
    rd = '0;
    if (it.op == OP_READ) begin
      case (it.off)
        REG_DATA: rd = dlab ? m_divisor[7:0] : 8'h00;
        REG_IER:  rd = dlab ? m_divisor[15:8] : {4'h0, m_ier};
        REG_IIR:  rd = IIR_NONE_PENDING;
        REG_LCR:  rd = m_lcr;
        REG_LSR: begin
          rd[LSR_THRE_BIT] = !m_thr_full;
          rd[LSR_TEMT_BIT] = !m_thr_full && (m_bits == '0);
        end
        default:  rd = 8'h00;
      endcase
    end else if (it.op == OP_WRITE) begin
      case (it.off)
        REG_DATA: begin
          if (dlab) begin
            m_divisor[7:0] = it.data;
          end else begin
            m_thr = it.data;
            m_thr_full = 1'b1;
          end
        end
        REG_IER: begin
          if (dlab) m_divisor[15:8] = it.data;
          else m_ier = it.data[3:0];
        end
        REG_LCR:  m_lcr = it.data;
        default: ;
      endcase
    end else if (it.op == OP_TICK) begin
      if (m_bits != '0) begin
        if (m_timer != '0) m_timer = m_timer - TIMER_W'(1);
        if (m_timer == '0) begin
          m_frame = {1'b1, m_frame[FRAME_W-1:1]};
          m_bits = m_bits - BITCNT_W'(1);
          if (m_bits != '0) m_timer = bit_ticks();
        end
      end
      // a held byte enters the shifter on the tick the stop bit ends, or on any tick while the shifter is idle
      if (m_bits == '0 && m_thr_full) begin
        m_frame = {1'b1, m_thr, 1'b0};
        m_bits = FRAME_BITS;
        m_timer = bit_ticks();
        m_thr_full = 1'b0;
        frames_started++;
      end
    end
    res.read_data = rd;
    res.serial_out = (m_bits != '0) ? m_frame[0] : 1'b1;
    res.holding_empty = !m_thr_full;
  endtask

  // stimulus generation; the divisor stays small whenever a tick is queued
  logic gen_dlab = 1'b0;
  int   gen_div = 0;

  task automatic put(input logic [OPCODE_W-1:0] op, input logic [OFFSET_W-1:0] off,
                     input logic [BYTE_W-1:0] data);
    bus_item_t it;
    it.op = op;
    it.off = off;
    it.data = data;
    bus_items.push_back(it);
  endtask

  task automatic set_lcr(input logic dlab);
    logic [BYTE_W-1:0] v;
    v = 8'($urandom);
    v[LCR_DLAB_BIT] = dlab;
    put(OP_WRITE, REG_LCR, v);
    gen_dlab = dlab;
    if ($urandom_range(0, 2) == 0) put(OP_READ, REG_LCR, 8'($urandom));
  endtask

  task automatic run_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) put(OP_READ, REG_LSR, 8'($urandom));
        else put(OP_READ, 3'($urandom), 8'($urandom));
      end
      put(OP_TICK, 3'($urandom), 8'($urandom));
    end
  endtask

  function automatic int frame_ticks();
    return 10 * ((gen_div == 0) ? 1 : gen_div) * int'(OVERSAMPLE_DEF);
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    bus_item_t it;
    logic calm;
    if (rst_ni) begin
      calm = bus_items.size() < CALM_TAIL;
      if (cycle_cnt % 128 == 0) idle_rate = $urandom_range(0, 3) * 2;
      if (!s_axis_tvalid || in_taken) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (bus_items.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) < idle_rate) begin
          src_gap = $urandom_range(0, 10);
          s_axis_tvalid <= 1'b0;
        end else begin
          it = bus_items.pop_front();
          s_axis_tdata <= {3'b000, it.data, it.off, it.op};
          s_axis_tvalid <= 1'b1;
        end
      end
      if (snk_gap != 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) < idle_rate) begin
        snk_gap = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on each accepted bus item, then check each accepted result
  always @(posedge clk_i) begin
    bus_item_t it;
    result_t   res;
    result_t   want;
    cycle_cnt <= cycle_cnt + 1;
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.op = s_axis_tdata[1:0];
        it.off = s_axis_tdata[4:2];
        it.data = s_axis_tdata[12:5];
        step_uart(it, res);
        due_results.push_back(res);
        items_taken++;
        if (it.op == OP_READ) reads_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("result with no item waiting: tdata %0h", m_axis_tdata);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata[7:0] !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tdata[8] !== want.serial_out) begin
            $error("serial_out: expected %0b, got %0b", want.serial_out, m_axis_tdata[8]);
            errors++;
          end
          if (m_axis_tdata[9] !== want.holding_empty) begin
            $error("holding_empty: expected %0b, got %0b", want.holding_empty,
                   m_axis_tdata[9]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n_directed;
    int pick;
    int ft;
    // directed: reset values of every offset, then the register map extremes
    for (int off = 0; off < 8; off++) put(OP_READ, 3'(off), 8'h00);
    put(OP_NONE, 3'h7, 8'hff);
    put(OP_WRITE, REG_IER, 8'hff);
    put(OP_READ, REG_IER, 8'h00);
    put(OP_WRITE, REG_LCR, 8'hff);
    put(OP_WRITE, REG_DATA, 8'hff);
    put(OP_WRITE, REG_IER, 8'hff);
    put(OP_READ, REG_DATA, 8'h00);
    put(OP_READ, REG_IER, 8'h00);
    // zero divisor, then back to the data register with 8N1 bits in lcr
    put(OP_WRITE, REG_DATA, 8'h00);
    put(OP_WRITE, REG_IER, 8'h00);
    put(OP_WRITE, REG_LCR, 8'h03);
    put(OP_READ, REG_LCR, 8'h00);
    put(OP_WRITE, REG_DATA, 8'h00);
    // second write while holding full replaces the byte
    put(OP_WRITE, REG_DATA, 8'hff);
    put(OP_READ, REG_LSR, 8'h00);
    put(OP_TICK, 3'h0, 8'h00);
    put(OP_READ, REG_LSR, 8'h00);
    put(OP_WRITE, REG_SCR, 8'hff);
    put(OP_READ, REG_SCR, 8'h00);
    n_directed = bus_items.size();
    gen_dlab = 1'b0;
    gen_div = 0;

    while (bus_items.size() < n_directed + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      ft = frame_ticks();
      if (pick < 45) begin
        if (gen_dlab) set_lcr(1'b0);
        put(OP_WRITE, REG_DATA, 8'($urandom));
        case ($urandom_range(0, 3))
          0: run_ticks(ft + 2);
          1: run_ticks($urandom_range(1, ft));
          2: begin
            // back-to-back bytes
            run_ticks($urandom_range(1, ft / 2));
            put(OP_WRITE, REG_DATA, 8'($urandom));
            run_ticks(2 * ft + 2);
          end
          default: begin
            put(OP_WRITE, REG_DATA, 8'($urandom));
            run_ticks(ft + 2);
          end
        endcase
      end else if (pick < 60) begin
        // small divisor, possibly in the middle of a frame
        set_lcr(1'b1);
        gen_div = $urandom_range(0, 2);
        put(OP_WRITE, REG_DATA, 8'(gen_div));
        put(OP_WRITE, REG_IER, 8'h00);
        put(OP_READ, REG_DATA, 8'($urandom));
        put(OP_READ, REG_IER, 8'($urandom));
        if ($urandom_range(0, 3) != 0) set_lcr(1'b0);
      end else if (pick < 68) begin
        // full-range divisor readback, restored before any tick
        set_lcr(1'b1);
        put(OP_WRITE, REG_DATA, 8'($urandom));
        put(OP_WRITE, REG_IER, 8'($urandom));
        put(OP_READ, REG_DATA, 8'($urandom));
        put(OP_READ, REG_IER, 8'($urandom));
        put(OP_WRITE, REG_DATA, 8'(gen_div));
        put(OP_WRITE, REG_IER, 8'h00);
        put(OP_READ, REG_IER, 8'($urandom));
        set_lcr(1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 6))
            0: put(OP_READ, 3'($urandom), 8'($urandom));
            1: put(OP_NONE, 3'($urandom), 8'($urandom));
            2: put(OP_WRITE, 3'($urandom_range(4, 7)), 8'($urandom));
            3: put(OP_WRITE, REG_IIR, 8'($urandom));
            4: begin
              if (gen_dlab) put(OP_WRITE, REG_IER, 8'h00);
              else put(OP_WRITE, REG_IER, 8'($urandom));
            end
            5: set_lcr(1'($urandom));
            default: run_ticks($urandom_range(1, 20));
          endcase
        end
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (bus_items.size() == 0 && !s_axis_tvalid);
    wait (due_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      errors++;
    end
    $display("run covered %0d bus items (%0d reads) and %0d serial frames started",
             items_taken, reads_taken, frames_started);
    $display("%0d mismatches after %0d cycles", errors, cycle_cnt);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
